@@ rtl/bssi_pkg.sv @@
package bssi_pkg;

  // Operation codes carried by the input transaction
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_OPUSH = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int OUT_W = 32;
  localparam int FILL_W = 5;
  localparam logic signed [OUT_W-1:0] POP_EMPTY_VAL = -32'sd999;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    latch_in;
    logic    set_status;
    status_t status_code;
    logic    push_wr;
    logic    pop_rd;
    logic    rev_init;
    logic    rev_rd;
    logic    rev_wi;
    logic    rev_wj;
    logic    op_init;
    logic    op_rd;
    logic    op_shift;
    logic    op_place;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    mode_t op;
    logic  is_empty;
    logic  is_full;
    logic  count_le1;
    logic  rev_more;
    logic  pos_zero;
    logic  less;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/bssi_if.sv @@
interface bssi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface bssi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic               is_empty;
  logic               is_full;
  logic [4:0]         fill_count;

  modport source (output valid, output popped_value, output status, output is_empty,
                  output is_full, output fill_count, input ready);
  modport sink (input valid, input popped_value, input status, input is_empty,
                input is_full, input fill_count, output ready);
endinterface

@@ rtl/bssi_ctrl.sv @@
module bssi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bssi_pkg::sts_t sts,
  output bssi_pkg::cmd_t cmd
);
  import bssi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_REV_RD = 8'b0000_0100,
    S_REV_WI = 8'b0000_1000,
    S_REV_WJ = 8'b0001_0000,
    S_OP_CHK = 8'b0010_0000,
    S_OP_CMP = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status_code = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt = S_FIN;
        case (sts.op)
          MODE_PUSH: begin
            if (sts.is_full) cmd.status_code = ST_FULL;
            else cmd.push_wr = 1'b1;
          end
          MODE_POP: begin
            if (sts.is_empty) cmd.status_code = ST_EMPTY;
            else cmd.pop_rd = 1'b1;
          end
          MODE_REV: begin
            if (!sts.count_le1) begin
              cmd.rev_init = 1'b1;
              state_nxt = S_REV_RD;
            end
          end
          default: begin
            if (sts.is_full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.op_init = 1'b1;
              state_nxt = S_OP_CHK;
            end
          end
        endcase
      end
      S_REV_RD: begin
        cmd.rev_rd = 1'b1;
        state_nxt = S_REV_WI;
      end
      S_REV_WI: begin
        cmd.rev_wi = 1'b1;
        state_nxt = S_REV_WJ;
      end
      S_REV_WJ: begin
        cmd.rev_wj = 1'b1;
        state_nxt = sts.rev_more ? S_REV_RD : S_FIN;
      end
      S_OP_CHK: begin
        if (sts.pos_zero) begin
          cmd.op_place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.op_rd = 1'b1;
          state_nxt = S_OP_CMP;
        end
      end
      S_OP_CMP: begin
        if (sts.less) begin
          cmd.op_shift = 1'b1;
          state_nxt = S_OP_CHK;
        end else begin
          cmd.op_place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/bssi_dp.sv @@
module bssi_dp #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_mode,
  input  logic signed [31:0]  in_value,
  input  bssi_pkg::cmd_t      cmd,
  output bssi_pkg::sts_t      sts,
  bssi_out_if.source          out_chan
);
  import bssi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]         count_r, count_nxt;
  mode_t                    op_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]            i_r, j_r, pos_r;
  status_t                  res_status_r;

  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_pop_r;
  logic [1:0]               out_status_r;
  logic                     out_empty_r, out_full_r;
  logic [FILL_W-1:0]        out_fill_r;

  logic signed [63:0]       in_ext, rd_ext;
  logic [AW-1:0]            top_addr, top_m1;
  logic                     wr_en, rd_a_en;
  logic [AW-1:0]            wr_addr, rd_a_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [AW:0]              i_inc, j_dec;
  logic [CNT_W+FILL_W-1:0]  cnt_ext;
  logic signed [OUT_W-1:0]  pop_val;
  logic                     full_w;

  // Wrap the input word to DATA_W bits, sign-extended
  assign in_ext = 64'(in_value);
  assign rd_ext = 64'(rd_a_q);

  assign top_addr = count_r[AW-1:0];
  assign top_m1 = top_addr - AW'(1);
  assign full_w = (count_r == CNT_W'(DEPTH));
  assign i_inc = {1'b0, i_r} + (AW+1)'(1);
  assign j_dec = {1'b0, j_r} - (AW+1)'(1);

  always_comb begin
    sts.op = op_r;
    sts.is_empty = (count_r == '0);
    sts.is_full = full_w;
    sts.count_le1 = (count_r <= CNT_W'(1));
    sts.rev_more = (i_inc < j_dec);
    sts.pos_zero = (pos_r == '0);
    sts.less = (val_r < rd_a_q);
    sts.out_free = !out_valid_r || out_chan.ready;
  end

  // Single write port
  always_comb begin
    wr_en = 1'b1;
    wr_addr = pos_r;
    wr_data = val_r;
    if (cmd.push_wr) begin
      wr_addr = top_addr;
    end else if (cmd.rev_wi) begin
      wr_addr = i_r;
      wr_data = rd_b_q;
    end else if (cmd.rev_wj) begin
      wr_addr = j_r;
      wr_data = rd_a_q;
    end else if (cmd.op_shift) begin
      wr_data = rd_a_q;
    end else if (!cmd.op_place) begin
      wr_en = 1'b0;
    end
  end

  // Read port A serves pop, reverse low side and the insert walk
  always_comb begin
    rd_a_en = cmd.pop_rd || cmd.rev_rd || cmd.op_rd;
    rd_a_addr = top_m1;
    if (cmd.rev_rd) rd_a_addr = i_r;
    else if (cmd.op_rd) rd_a_addr = pos_r - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_a_en) rd_a_q <= mem[rd_a_addr];
    if (cmd.rev_rd) rd_b_q <= mem[j_r];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_wr || cmd.op_place) count_nxt = count_r + CNT_W'(1);
    else if (cmd.pop_rd) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= mode_t'(in_mode);
      val_r <= in_ext[DATA_W-1:0];
    end
    if (cmd.set_status) res_status_r <= cmd.status_code;
    if (cmd.rev_init) begin
      i_r <= '0;
      j_r <= top_m1;
    end else if (cmd.rev_wj) begin
      i_r <= i_inc[AW-1:0];
      j_r <= j_dec[AW-1:0];
    end
    if (cmd.op_init) pos_r <= top_addr;
    else if (cmd.op_shift) pos_r <= pos_r - AW'(1);
  end

  always_comb begin
    pop_val = '0;
    if (op_r == MODE_POP) begin
      pop_val = (res_status_r == ST_EMPTY) ? POP_EMPTY_VAL : rd_ext[OUT_W-1:0];
    end
  end

  assign cnt_ext = (CNT_W+FILL_W)'(count_r);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pop_r <= pop_val;
      out_status_r <= res_status_r;
      out_empty_r <= (count_r == '0);
      out_full_r <= full_w;
      out_fill_r <= cnt_ext[FILL_W-1:0];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.popped_value = out_pop_r;
  assign out_chan.status = out_status_r;
  assign out_chan.is_empty = out_empty_r;
  assign out_chan.is_full = out_full_r;
  assign out_chan.fill_count = out_fill_r;

endmodule

@@ rtl/bounded_stack_sorted_insert_top.sv @@
// Bounded stack of signed words with push, pop, reverse and ordered push.
// Input channel in_chan: valid/ready with mode and value; a transaction is
// taken when valid and ready are both high. Ready is high only while the
// block has no operation in progress, so one transaction is worked at a time.
// Output channel out_chan: one result transaction per input transaction,
// carrying popped_value, status, is_empty, is_full and fill_count.
// Controller steps from the accepting edge to result valid:
//   push, pop, any rejected operation, reverse of fewer than two entries:
//   decode, then finish; reverse: one read and two writes per swapped pair;
//   ordered push: one memory read and one write per walk step, the walk
//   ending at the bottom of the stack or on a compare.
// Ready returns in the same cycle as result valid.
// The entry memory has one write port and two registered read ports.
// Reset empties the stack at once; memory contents stay undefined and are
// never read before being written. The result sits in an output register:
// when the receiver stalls, the block still takes the next input but holds
// its new result until the register frees.
module bounded_stack_sorted_insert_top #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bssi_in_if.sink     in_chan,
  bssi_out_if.source  out_chan
);
  import bssi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ready_w;

  // Controller: sequence each operation
  bssi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready_w),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_chan.ready = ready_w;

  // Datapath: entry memory, pointers, result register
  bssi_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mode  (in_chan.mode),
    .in_value (in_chan.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_chan (out_chan)
  );

endmodule

@@ rtl/bssi_chk.sv @@
module bssi_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_popped_value,
  input logic [1:0]         out_status,
  input logic               out_is_empty,
  input logic               out_is_full,
  input logic [4:0]         out_fill_count
);
  import bssi_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_popped_value) && $stable(out_status)
      && $stable(out_fill_count))
    else $error("result changed while stalled");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_fill_count == '0 && !out_is_full)
    else $error("empty flag disagrees with fill count");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_is_full && out_popped_value == '0)
    else $error("full rejection without full stack");

  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_is_empty
      && out_popped_value == POP_EMPTY_VAL)
    else $error("empty rejection with wrong flags or value");

endmodule

bind bounded_stack_sorted_insert_top bssi_chk u_bssi_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_popped_value (out_chan.popped_value),
  .out_status       (out_chan.status),
  .out_is_empty     (out_chan.is_empty),
  .out_is_full      (out_chan.is_full),
  .out_fill_count   (out_chan.fill_count)
);
